>>> rtl/qrs_pkg.sv
// shared types and constants of the quadratic root solver
package qrs_pkg;

   // epsilon register: fixed 32-bit width, reset near 1e-5 in q0.32
   localparam int          EPS_WIDTH   = 32;
   localparam logic [31:0] EPS_RESET   = 32'd42950;

   // entries of the queue between front and back
   localparam int          QUEUE_DEPTH = 4;

   // per-word classification made by the front
   typedef struct packed {
      logic lin;      // a near zero: linear case
      logic b_zero;
      logic a_neg;
      logic b_neg;
      logic c_neg;
   } cls_type;

   // queue status toward front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> rtl/quadratic_root_solver_core.sv
// top level of the quadratic root solver: front, queue, back and result register
//
//   channel | direction | handshake          | word
//   req     | in        | req_valid/req_stall | coef_a, coef_b, coef_c (signed q.f)
//   rsp     | out       | rsp_valid/rsp_stall | root_plus, root_minus, roots_real,
//           |           |                     | divide_by_zero, saturated
//   csr     | in        | csr_valid/csr_ready | epsilon (32 bits)
//
// one word per cycle sustained while rsp_stall stays low; the pipe depth is
// set by the one-bit-per-stage square root (COEF_WIDTH+2 stages) and the two
// restoring quotient lanes (COEF_WIDTH+FRAC_BITS+2 stages)
// reset clears all valid bits, the queue pointers and sets epsilon to its default
// rsp_stall on a valid result freezes the whole back pipe; the front keeps filling the queue until
// it is full, then raises req_stall
module quadratic_root_solver_core #(
   parameter int COEF_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   // coefficient words in
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_a,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_b,
   input  logic signed [COEF_WIDTH-1:0]  req_coef_c,
   // root words out
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COEF_WIDTH-1:0]  rsp_root_plus,
   output logic signed [COEF_WIDTH-1:0]  rsp_root_minus,
   output logic                          rsp_roots_real,
   output logic                          rsp_divide_by_zero,
   output logic                          rsp_saturated,
   // epsilon register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [qrs_pkg::EPS_WIDTH-1:0] csr_data
);

   localparam int W  = COEF_WIDTH;
   localparam int QD = 3*W + $bits(qrs_pkg::cls_type);

   // epsilon register; the user must write it only while idle, the block does not enforce this
   logic [qrs_pkg::EPS_WIDTH-1:0] eps_ff, eps_in;

   // front to queue
   logic                  fr_valid;
   logic [W-1:0]          fr_ma, fr_mb, fr_mc;
   qrs_pkg::cls_type      fr_cls;
   logic                  q_push, q_pop;
   qrs_pkg::q_status_type q_status;
   logic [QD-1:0]         q_head;

   // queue head fields
   logic [W-1:0]          hd_ma, hd_mb, hd_mc;
   qrs_pkg::cls_type      hd_cls;

   // back pipe and result register
   logic                  adv;
   logic                  bk_valid, bk_real, bk_dz, bk_sat;
   logic [W-1:0]          bk_rp, bk_rm;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]          rsp_rp_ff, rsp_rm_ff;
   logic                  rsp_real_ff, rsp_dz_ff, rsp_sat_ff;

   assign csr_ready = 1'b1;
   assign eps_in    = (csr_valid && csr_ready) ? csr_data : eps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= qrs_pkg::EPS_RESET;
      end else begin
         eps_ff <= eps_in;
      end
   end

   // front: magnitudes, signs and the near-zero test on a
   qrs_front #(
      .W (W),
      .F (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .coef_a    (req_coef_a),
      .coef_b    (req_coef_b),
      .coef_c    (req_coef_c),
      .eps       (eps_ff),
      .out_valid (fr_valid),
      .out_ready (!q_status.full),
      .mag_a     (fr_ma),
      .mag_b     (fr_mb),
      .mag_c     (fr_mc),
      .cls       (fr_cls)
   );

   assign q_push = fr_valid && !q_status.full;

   // queue decouples the front from back-pipe stalls
   qrs_queue #(
      .DW    (QD),
      .DEPTH (qrs_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({fr_ma, fr_mb, fr_mc, fr_cls}),
      .pop       (q_pop),
      .pop_data  (q_head),
      .status    (q_status)
   );

   assign {hd_ma, hd_mb, hd_mc, hd_cls} = q_head;

   // back pipe moves whenever the result register can take a word
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv && !q_status.empty;

   qrs_back #(
      .W (W),
      .F (FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .in_valid       (!q_status.empty),
      .in_mag_a       (hd_ma),
      .in_mag_b       (hd_mb),
      .in_mag_c       (hd_mc),
      .in_cls         (hd_cls),
      .eps            (eps_ff),
      .out_valid      (bk_valid),
      .out_root_plus  (bk_rp),
      .out_root_minus (bk_rm),
      .out_real       (bk_real),
      .out_dz         (bk_dz),
      .out_sat        (bk_sat)
   );

   // result register
   assign rsp_valid_in = adv ? bk_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_rp_ff   <= bk_rp;
         rsp_rm_ff   <= bk_rm;
         rsp_real_ff <= bk_real;
         rsp_dz_ff   <= bk_dz;
         rsp_sat_ff  <= bk_sat;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_root_plus      = rsp_rp_ff;
   assign rsp_root_minus     = rsp_rm_ff;
   assign rsp_roots_real     = rsp_real_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;
   assign rsp_saturated      = rsp_sat_ff;

   // queue never written while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fr_valid && q_status.full |-> !q_push)
      else $error("queue push while full");

   // divide-by-zero words carry zero roots, real set, no saturation
   a_dz_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |->
         rsp_root_plus == '0 && rsp_root_minus == '0 && rsp_roots_real && !rsp_saturated)
      else $error("divide-by-zero word malformed");

   // front only stalls when holding a word the queue cannot take
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> fr_valid && q_status.full)
      else $error("front stalled without a full queue");

endmodule

>>> rtl/qrs_front.sv
// front stage: takes coefficient words, forms magnitudes and classifies them
module qrs_front #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_stall,
   input  logic signed [W-1:0]             coef_a,
   input  logic signed [W-1:0]             coef_b,
   input  logic signed [W-1:0]             coef_c,
   input  logic [qrs_pkg::EPS_WIDTH-1:0]   eps,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [W-1:0]                    mag_a,
   output logic [W-1:0]                    mag_b,
   output logic [W-1:0]                    mag_c,
   output qrs_pkg::cls_type                cls
);

   localparam int EW = qrs_pkg::EPS_WIDTH + 1;
   localparam int CW = (W > EW) ? W : EW;

   logic             valid_ff, valid_in;
   logic [W-1:0]     mag_a_ff, mag_b_ff, mag_c_ff;
   logic [W-1:0]     mag_a_in, mag_b_in, mag_c_in;
   qrs_pkg::cls_type cls_ff, cls_in;
   logic [EW-1:0]    thr;

   assign in_stall = valid_ff && !out_ready;

   // threshold on |a| is epsilon rounded up to whole q.f units
   assign thr = (EW'(eps) + ((EW'(1) << F) - EW'(1))) >> F;

   always_comb begin
      mag_a_in      = coef_a[W-1] ? $unsigned(-coef_a) : $unsigned(coef_a);
      mag_b_in      = coef_b[W-1] ? $unsigned(-coef_b) : $unsigned(coef_b);
      mag_c_in      = coef_c[W-1] ? $unsigned(-coef_c) : $unsigned(coef_c);
      cls_in.lin    = (coef_a == '0) || (CW'(mag_a_in) < CW'(thr));
      cls_in.b_zero = (coef_b == '0);
      cls_in.a_neg  = coef_a[W-1];
      cls_in.b_neg  = coef_b[W-1];
      cls_in.c_neg  = coef_c[W-1];
      valid_in      = in_stall ? valid_ff : in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_b_in;
         mag_c_ff <= mag_c_in;
         cls_ff   <= cls_in;
      end
   end

   assign out_valid = valid_ff;
   assign mag_a     = mag_a_ff;
   assign mag_b     = mag_b_ff;
   assign mag_c     = mag_c_ff;
   assign cls       = cls_ff;

endmodule

>>> rtl/qrs_queue.sv
// small fifo between front and back
module qrs_queue #(
   parameter int DW    = 8,
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DW-1:0]         push_data,
   input  logic                  pop,
   output logic [DW-1:0]         pop_data,
   output qrs_pkg::q_status_type status
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DW-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (AW+1)'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

>>> rtl/qrs_back.sv
// back pipeline: discriminant, bit-serial root stages, two quotient lanes
module qrs_back #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [W-1:0]                  in_mag_a,
   input  logic [W-1:0]                  in_mag_b,
   input  logic [W-1:0]                  in_mag_c,
   input  qrs_pkg::cls_type              in_cls,
   input  logic [qrs_pkg::EPS_WIDTH-1:0] eps,
   output logic                          out_valid,
   output logic [W-1:0]                  out_root_plus,
   output logic [W-1:0]                  out_root_minus,
   output logic                          out_real,
   output logic                          out_dz,
   output logic                          out_sat
);

   localparam int DW  = 2*W + 3;     // discriminant magnitude
   localparam int SQ  = W + 2;       // root bits
   localparam int TW  = 2*SQ + 1;    // root trial width
   localparam int NW  = W + 3;       // signed numerator
   localparam int MW  = W + 2;       // numerator magnitude
   localparam int QW  = MW + F;      // quotient bits
   localparam int DNW = W + 1;       // denominator
   localparam int CW  = (DW > qrs_pkg::EPS_WIDTH) ? DW : qrs_pkg::EPS_WIDTH;

   // stage a: operand register
   logic             va_ff;
   logic [W-1:0]     a_ma_ff, a_mb_ff, a_mc_ff;
   qrs_pkg::cls_type a_cls_ff;

   // stage b: products
   logic             vb_ff;
   logic [2*W-1:0]   b_bb_ff, b_ac_ff;
   logic [W-1:0]     b_ma_ff, b_mb_ff, b_mc_ff;
   qrs_pkg::cls_type b_cls_ff;

   // discriminant
   logic [DW-1:0]    dm_in;
   logic             dneg_in, dreal_in;

   // root stages
   logic             sq_v_ff    [SQ+1];
   logic [DW-1:0]    sq_rem_ff  [SQ+1];
   logic [SQ-1:0]    sq_root_ff [SQ+1];
   logic [W-1:0]     sq_ma_ff   [SQ+1];
   logic [W-1:0]     sq_mb_ff   [SQ+1];
   logic [W-1:0]     sq_mc_ff   [SQ+1];
   qrs_pkg::cls_type sq_cls_ff  [SQ+1];
   logic             sq_dneg_ff [SQ+1];
   logic             sq_dreal_ff[SQ+1];

   // quotient stages
   logic             dv_v_ff    [QW+1];
   logic [QW-1:0]    dv_n1_ff   [QW+1];
   logic [QW-1:0]    dv_n2_ff   [QW+1];
   logic [DNW-1:0]   dv_r1_ff   [QW+1];
   logic [DNW-1:0]   dv_r2_ff   [QW+1];
   logic [QW-1:0]    dv_q1_ff   [QW+1];
   logic [QW-1:0]    dv_q2_ff   [QW+1];
   logic [DNW-1:0]   dv_den_ff  [QW+1];
   logic             dv_neg1_ff [QW+1];
   logic             dv_neg2_ff [QW+1];
   logic             dv_dz_ff   [QW+1];
   logic             dv_real_ff [QW+1];

   // numerator forming
   logic [NW-1:0]    nb, n1, n2;
   logic [DNW-1:0]   den_in;
   logic             den_neg, dz_in, real_in;
   logic [MW-1:0]    n1_mag, n2_mag;

   // operand and product stages
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ma_ff  <= in_mag_a;
         a_mb_ff  <= in_mag_b;
         a_mc_ff  <= in_mag_c;
         a_cls_ff <= in_cls;
         b_bb_ff  <= a_mb_ff * a_mb_ff;
         b_ac_ff  <= a_ma_ff * a_mc_ff;
         b_ma_ff  <= a_ma_ff;
         b_mb_ff  <= a_mb_ff;
         b_mc_ff  <= a_mc_ff;
         b_cls_ff <= a_cls_ff;
      end
   end

   // b*b - 4ac as sign and magnitude
   always_comb begin
      dneg_in = 1'b0;
      if (b_cls_ff.a_neg ^ b_cls_ff.c_neg) begin
         dm_in = DW'(b_bb_ff) + (DW'(b_ac_ff) << 2);
      end else if (DW'(b_bb_ff) >= (DW'(b_ac_ff) << 2)) begin
         dm_in = DW'(b_bb_ff) - (DW'(b_ac_ff) << 2);
      end else begin
         dm_in   = (DW'(b_ac_ff) << 2) - DW'(b_bb_ff);
         dneg_in = 1'b1;
      end
      dreal_in = CW'(dm_in) < CW'(eps);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0]   <= dm_in;
         sq_root_ff[0]  <= '0;
         sq_ma_ff[0]    <= b_ma_ff;
         sq_mb_ff[0]    <= b_mb_ff;
         sq_mc_ff[0]    <= b_mc_ff;
         sq_cls_ff[0]   <= b_cls_ff;
         sq_dneg_ff[0]  <= dneg_in;
         sq_dreal_ff[0] <= dreal_in;
      end
   end

   // one root bit per stage, remainder kept as x - root^2
   for (genvar i = 0; i < SQ; i++) begin : g_sqrt
      localparam int K = SQ - 1 - i;
      logic [TW-1:0] trial;
      logic          take;
      logic [DW-1:0] rem_in;
      logic [SQ-1:0] root_in;

      always_comb begin
         trial   = (TW'(sq_root_ff[i]) << (K + 1)) + (TW'(1) << (2 * K));
         take    = TW'(sq_rem_ff[i]) >= trial;
         rem_in  = take ? sq_rem_ff[i] - DW'(trial) : sq_rem_ff[i];
         root_in = take ? (sq_root_ff[i] | (SQ'(1) << K)) : sq_root_ff[i];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[i+1] <= sq_v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[i+1]   <= rem_in;
            sq_root_ff[i+1]  <= root_in;
            sq_ma_ff[i+1]    <= sq_ma_ff[i];
            sq_mb_ff[i+1]    <= sq_mb_ff[i];
            sq_mc_ff[i+1]    <= sq_mc_ff[i];
            sq_cls_ff[i+1]   <= sq_cls_ff[i];
            sq_dneg_ff[i+1]  <= sq_dneg_ff[i];
            sq_dreal_ff[i+1] <= sq_dreal_ff[i];
         end
      end
   end

   // numerators and denominator per case
   always_comb begin
      nb = sq_cls_ff[SQ].b_neg ? NW'(sq_mb_ff[SQ]) : NW'(0) - NW'(sq_mb_ff[SQ]);
      dz_in   = 1'b0;
      real_in = 1'b1;
      if (sq_cls_ff[SQ].lin) begin
         n1 = sq_cls_ff[SQ].c_neg ? NW'(sq_mc_ff[SQ]) : NW'(0) - NW'(sq_mc_ff[SQ]);
         n2      = n1;
         den_in  = DNW'(sq_mb_ff[SQ]);
         den_neg = sq_cls_ff[SQ].b_neg;
         dz_in   = sq_cls_ff[SQ].b_zero;
      end else if (!sq_dneg_ff[SQ]) begin
         n1      = nb + NW'(sq_root_ff[SQ]);
         n2      = nb - NW'(sq_root_ff[SQ]);
         den_in  = {sq_ma_ff[SQ], 1'b0};
         den_neg = sq_cls_ff[SQ].a_neg;
      end else begin
         n1      = nb;
         n2      = nb;
         den_in  = {sq_ma_ff[SQ], 1'b0};
         den_neg = sq_cls_ff[SQ].a_neg;
         real_in = sq_dreal_ff[SQ];
      end
      n1_mag = n1[NW-1] ? MW'(NW'(0) - n1) : MW'(n1);
      n2_mag = n2[NW-1] ? MW'(NW'(0) - n2) : MW'(n2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[SQ];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_n1_ff[0]   <= {n1_mag, F'(0)};
         dv_n2_ff[0]   <= {n2_mag, F'(0)};
         dv_r1_ff[0]   <= '0;
         dv_r2_ff[0]   <= '0;
         dv_q1_ff[0]   <= '0;
         dv_q2_ff[0]   <= '0;
         dv_den_ff[0]  <= den_in;
         dv_neg1_ff[0] <= n1[NW-1] ^ den_neg;
         dv_neg2_ff[0] <= n2[NW-1] ^ den_neg;
         dv_dz_ff[0]   <= dz_in;
         dv_real_ff[0] <= real_in;
      end
   end

   // restoring division, one quotient bit per stage in both lanes
   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [DNW:0]   sh1, sh2;
      logic           ge1, ge2;
      logic [DNW-1:0] r1_in, r2_in;

      always_comb begin
         sh1   = {dv_r1_ff[j], dv_n1_ff[j][QW-1]};
         sh2   = {dv_r2_ff[j], dv_n2_ff[j][QW-1]};
         ge1   = sh1 >= (DNW+1)'(dv_den_ff[j]);
         ge2   = sh2 >= (DNW+1)'(dv_den_ff[j]);
         r1_in = ge1 ? DNW'(sh1 - (DNW+1)'(dv_den_ff[j])) : DNW'(sh1);
         r2_in = ge2 ? DNW'(sh2 - (DNW+1)'(dv_den_ff[j])) : DNW'(sh2);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_n1_ff[j+1]   <= dv_n1_ff[j] << 1;
            dv_n2_ff[j+1]   <= dv_n2_ff[j] << 1;
            dv_r1_ff[j+1]   <= r1_in;
            dv_r2_ff[j+1]   <= r2_in;
            dv_q1_ff[j+1]   <= {dv_q1_ff[j][QW-2:0], ge1};
            dv_q2_ff[j+1]   <= {dv_q2_ff[j][QW-2:0], ge2};
            dv_den_ff[j+1]  <= dv_den_ff[j];
            dv_neg1_ff[j+1] <= dv_neg1_ff[j];
            dv_neg2_ff[j+1] <= dv_neg2_ff[j];
            dv_dz_ff[j+1]   <= dv_dz_ff[j];
            dv_real_ff[j+1] <= dv_real_ff[j];
         end
      end
   end

   // sign, saturation and the divide-by-zero override
   logic [QW-1:0] half, lim1, lim2;
   logic          sat1, sat2;
   logic [W-1:0]  max_pos, min_neg;

   always_comb begin
      half    = QW'(1) << (W - 1);
      max_pos = {1'b0, {(W-1){1'b1}}};
      min_neg = {1'b1, {(W-1){1'b0}}};
      lim1    = dv_neg1_ff[QW] ? half : half - QW'(1);
      lim2    = dv_neg2_ff[QW] ? half : half - QW'(1);
      sat1    = dv_q1_ff[QW] > lim1;
      sat2    = dv_q2_ff[QW] > lim2;
      if (dv_dz_ff[QW]) begin
         out_root_plus  = '0;
         out_root_minus = '0;
         out_sat        = 1'b0;
         out_real       = 1'b1;
      end else begin
         if (sat1) begin
            out_root_plus = dv_neg1_ff[QW] ? min_neg : max_pos;
         end else begin
            out_root_plus = dv_neg1_ff[QW] ? W'(0) - dv_q1_ff[QW][W-1:0]
                                           : dv_q1_ff[QW][W-1:0];
         end
         if (sat2) begin
            out_root_minus = dv_neg2_ff[QW] ? min_neg : max_pos;
         end else begin
            out_root_minus = dv_neg2_ff[QW] ? W'(0) - dv_q2_ff[QW][W-1:0]
                                            : dv_q2_ff[QW][W-1:0];
         end
         out_sat  = sat1 || sat2;
         out_real = dv_real_ff[QW];
      end
      out_dz    = dv_dz_ff[QW];
      out_valid = dv_v_ff[QW];
   end

endmodule
